>>> rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants, segment codes, register indexes and pipeline tag type
// for the ADSR envelope level block.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Default width of the time fields and time registers
    localparam int TIME_BITS_DEF = 24;

    // Level format: Q1.15, full scale is 1.0
    localparam int LEVEL_BITS = 16;
    localparam int QUOT_BITS  = 16;
    localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 16'h8000;

    // Register reset values
    localparam int ATTACK_RESET  = 441;
    localparam int DECAY_RESET   = 4410;
    localparam int SUSTAIN_RESET = 22938;
    localparam int RELEASE_RESET = 4410;

    // Envelope segment codes
    typedef enum logic [2:0] {
        SEG_ATTACK  = 3'd0,
        SEG_DECAY   = 3'd1,
        SEG_SUSTAIN = 3'd2,
        SEG_RELEASE = 3'd3,
        SEG_DONE    = 3'd4
    } seg_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } reg_idx_t;

    // Control tag that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        seg_t seg;
    } adsr_tag_t;

endpackage

>>> rtl/adsr_front.sv
// ----------------------------------------------------------------------------
// adsr_front
// Segment selection and operand setup (stage 1), then the numerator
// product (stage 2) that feeds the divider cell chain.
// ----------------------------------------------------------------------------
module adsr_front #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [TIME_BITS-1:0]                   t,
    input  logic [TIME_BITS-1:0]                   len,
    input  logic [TIME_BITS-1:0]                   attack,
    input  logic [TIME_BITS-1:0]                   decay,
    input  logic [TIME_BITS-1:0]                   release_len,
    input  logic [adsr_pkg::LEVEL_BITS-1:0]        sustain,
    output adsr_pkg::adsr_tag_t                    tag_out,
    output logic [TIME_BITS+adsr_pkg::QUOT_BITS-1:0] prod_out,
    output logic [TIME_BITS-1:0]                   div_out
);
    import adsr_pkg::*;

    localparam int NW = TIME_BITS + QUOT_BITS;

    logic [TIME_BITS:0]     sum_ad;
    logic [TIME_BITS:0]     sum_tr;
    seg_t                   seg_next;
    logic [LEVEL_BITS-1:0]  x_next;
    logic [TIME_BITS-1:0]   y_next;
    logic [TIME_BITS-1:0]   dv_next;

    adsr_tag_t              tag1_reg;
    logic [LEVEL_BITS-1:0]  x1_reg;
    logic [TIME_BITS-1:0]   y1_reg;
    logic [TIME_BITS-1:0]   dv1_reg;

    adsr_tag_t              tag2_reg;
    logic [NW-1:0]          prod2_reg;
    logic [NW-1:0]          prod2_next;
    logic [TIME_BITS-1:0]   dv2_reg;

    // Segment boundaries, tested in order; each picks multiplier and divisor
    always_comb
    begin
        sum_ad = {1'b0, attack} + {1'b0, decay};
        sum_tr = {1'b0, t} + {1'b0, release_len};
        if (t < attack)
        begin
            seg_next = SEG_ATTACK;
            x_next   = FULL_SCALE;
            y_next   = t;
            dv_next  = attack;
        end
        else if ({1'b0, t} < sum_ad)
        begin
            seg_next = SEG_DECAY;
            x_next   = FULL_SCALE - sustain;
            y_next   = t - attack;
            dv_next  = decay;
        end
        else if (sum_tr < {1'b0, len})
        begin
            seg_next = SEG_SUSTAIN;
            x_next   = '0;
            y_next   = '0;
            dv_next  = TIME_BITS'(1);
        end
        else if (t < len)
        begin
            seg_next = SEG_RELEASE;
            x_next   = sustain;
            y_next   = len - t;
            dv_next  = release_len;
        end
        else
        begin
            seg_next = SEG_DONE;
            x_next   = '0;
            y_next   = '0;
            dv_next  = TIME_BITS'(1);
        end
    end

    // Numerator product
    assign prod2_next = NW'(x1_reg) * NW'(y1_reg);

    // Stage control: valid flag and segment tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg.valid <= in_valid;
            tag1_reg.seg   <= seg_next;
            tag2_reg       <= tag1_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg       <= x_next;
            y1_reg       <= y_next;
            dv1_reg      <= dv_next;
            prod2_reg    <= prod2_next;
            dv2_reg      <= dv1_reg;
        end
    end

    assign tag_out  = tag2_reg;
    assign prod_out = prod2_reg;
    assign div_out  = dv2_reg;

endmodule

>>> rtl/adsr_div_cell.sv
// ----------------------------------------------------------------------------
// adsr_div_cell
// One restoring-division cell: resolves a single quotient bit and hands the
// partial remainder, divisor and tag to the next cell.
// ----------------------------------------------------------------------------
module adsr_div_cell #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF,
    parameter int SHIFT     = 0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  adsr_pkg::adsr_tag_t                      tag_in,
    input  logic [TIME_BITS+adsr_pkg::QUOT_BITS-1:0] rem_in,
    input  logic [TIME_BITS-1:0]                     div_in,
    input  logic [adsr_pkg::QUOT_BITS-1:0]           quot_in,
    output adsr_pkg::adsr_tag_t                      tag_out,
    output logic [TIME_BITS+adsr_pkg::QUOT_BITS-1:0] rem_out,
    output logic [TIME_BITS-1:0]                     div_out,
    output logic [adsr_pkg::QUOT_BITS-1:0]           quot_out
);
    import adsr_pkg::*;

    localparam int NW = TIME_BITS + QUOT_BITS;
    localparam logic [QUOT_BITS-1:0] QBIT = QUOT_BITS'(1) << SHIFT;

    logic [NW-1:0]        dsh;
    logic                 take;
    logic [NW-1:0]        rem_next;
    logic [QUOT_BITS-1:0] quot_next;

    adsr_tag_t            tag_reg;
    logic [NW-1:0]        rem_reg;
    logic [TIME_BITS-1:0] div_reg;
    logic [QUOT_BITS-1:0] quot_reg;

    // Trial subtract of the shifted divisor
    always_comb
    begin
        dsh       = NW'(div_in) << SHIFT;
        take      = (rem_in >= dsh);
        rem_next  = take ? (rem_in - dsh) : rem_in;
        quot_next = take ? (quot_in | QBIT) : quot_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg     <= rem_next;
            div_reg     <= div_in;
            quot_reg    <= quot_next;
        end
    end

    assign tag_out  = tag_reg;
    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign quot_out = quot_reg;

endmodule

>>> rtl/adsr_out_stage.sv
// ----------------------------------------------------------------------------
// adsr_out_stage
// Maps quotient and segment to the final level, then holds results in an
// output register backed by a skid register. Pipeline advance is gated only
// by the skid register, so output stalls never reach the input combinationally.
// ----------------------------------------------------------------------------
module adsr_out_stage #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  adsr_pkg::adsr_tag_t                      tag_in,
    input  logic [adsr_pkg::QUOT_BITS-1:0]           quot_in,
    input  logic [TIME_BITS+adsr_pkg::QUOT_BITS-1:0] rem_in,
    input  logic [TIME_BITS-1:0]                     div_in,
    input  logic [adsr_pkg::LEVEL_BITS-1:0]          sustain,
    output logic                                     pipe_en,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [adsr_pkg::LEVEL_BITS-1:0]          m_tdata,
    output logic [2:0]                               m_tuser
);
    import adsr_pkg::*;

    localparam int NW = TIME_BITS + QUOT_BITS;

    logic [LEVEL_BITS-1:0] level_next;
    logic                  push;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [LEVEL_BITS-1:0] m_level_reg;
    logic [LEVEL_BITS-1:0] m_level_next;
    seg_t                  m_seg_reg;
    seg_t                  m_seg_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic [LEVEL_BITS-1:0] skid_level_reg;
    seg_t                  skid_seg_reg;

    // Level per segment
    always_comb
    begin
        case (tag_in.seg)
            SEG_ATTACK:  level_next = quot_in;
            SEG_DECAY:   level_next = FULL_SCALE - quot_in;
            SEG_SUSTAIN: level_next = sustain;
            SEG_RELEASE: level_next = quot_in;
            default:     level_next = '0;
        endcase
    end

    assign pipe_en = !skid_valid_reg;
    assign push    = tag_in.valid && pipe_en;

    // Output register and skid control
    always_comb
    begin
        m_valid_next    = m_valid_reg;
        m_level_next    = m_level_reg;
        m_seg_next      = m_seg_reg;
        skid_valid_next = skid_valid_reg;
        if (!m_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                m_valid_next = 1'b1;
                m_level_next = skid_level_reg;
                m_seg_next   = skid_seg_reg;
            end
            else
            begin
                m_valid_next = push;
                m_level_next = level_next;
                m_seg_next   = tag_in.seg;
            end
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_level_reg <= m_level_next;
        m_seg_reg   <= m_seg_next;
        if (push)
        begin
            skid_level_reg <= level_next;
            skid_seg_reg   <= tag_in.seg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_level_reg;
    assign m_tuser  = m_seg_reg;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds data while output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_in.valid && (tag_in.seg == SEG_ATTACK || tag_in.seg == SEG_DECAY
            || tag_in.seg == SEG_RELEASE)) |-> (rem_in < NW'(div_in)))
        else $error("divider remainder not below divisor");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_level_reg <= FULL_SCALE))
        else $error("envelope level above full scale");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_seg_reg == SEG_DONE) |-> (m_level_reg == '0))
        else $error("finished segment with nonzero level");

endmodule

>>> rtl/adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level
// Piecewise-linear ADSR envelope level in Q1.15 from elapsed time and note
// length, using a pipelined chain of 16 restoring-division cells.
// Pipeline: 2 front stages, one cell per quotient bit, output register.
// Throughput: one transaction per cycle; the whole pipeline pauses only
//   while the skid register behind the output register is occupied.
// Reset: asynchronous, active low; clears valid flags and loads the
//   configuration registers with their default values.
// ----------------------------------------------------------------------------
module adsr_envelope_level #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [TIME_BITS-1:0]            cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [TIME_BITS-1:0] elapsed_samples, [2*TIME_BITS-1:TIME_BITS] note_length_samples
    input  logic [((2*TIME_BITS+7)/8)*8-1:0] s_tdata,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] level
    output logic [adsr_pkg::LEVEL_BITS-1:0] m_tdata,
    // [2:0] segment
    output logic [2:0]                      m_tuser
);
    import adsr_pkg::*;

    localparam int NW = TIME_BITS + QUOT_BITS;

    logic [TIME_BITS-1:0]  attack_reg;
    logic [TIME_BITS-1:0]  decay_reg;
    logic [LEVEL_BITS-1:0] sustain_reg;
    logic [TIME_BITS-1:0]  release_reg;
    logic [LEVEL_BITS-1:0] sustain_sat;
    logic                  pipe_en;

    adsr_tag_t             tag_c  [0:QUOT_BITS];
    logic [NW-1:0]         rem_c  [0:QUOT_BITS];
    logic [TIME_BITS-1:0]  div_c  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0]  quot_c [0:QUOT_BITS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= TIME_BITS'(ATTACK_RESET);
            decay_reg   <= TIME_BITS'(DECAY_RESET);
            sustain_reg <= LEVEL_BITS'(SUSTAIN_RESET);
            release_reg <= TIME_BITS'(RELEASE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ATTACK:  attack_reg  <= cfg_wdata;
                REG_DECAY:   decay_reg   <= cfg_wdata;
                REG_SUSTAIN: sustain_reg <= cfg_wdata[LEVEL_BITS-1:0];
                REG_RELEASE: release_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Sustain saturates at full scale
    assign sustain_sat = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;

    assign s_tready = pipe_en;

    adsr_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (s_tvalid),
        .t           (s_tdata[TIME_BITS-1:0]),
        .len         (s_tdata[2*TIME_BITS-1:TIME_BITS]),
        .attack      (attack_reg),
        .decay       (decay_reg),
        .release_len (release_reg),
        .sustain     (sustain_sat),
        .tag_out     (tag_c[0]),
        .prod_out    (rem_c[0]),
        .div_out     (div_c[0])
    );

    assign quot_c[0] = '0;

    // Divider cell chain, most significant quotient bit first
    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_cell
        adsr_div_cell #(
            .TIME_BITS (TIME_BITS),
            .SHIFT     (QUOT_BITS - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en),
            .tag_in   (tag_c[k]),
            .rem_in   (rem_c[k]),
            .div_in   (div_c[k]),
            .quot_in  (quot_c[k]),
            .tag_out  (tag_c[k+1]),
            .rem_out  (rem_c[k+1]),
            .div_out  (div_c[k+1]),
            .quot_out (quot_c[k+1])
        );
    end

    adsr_out_stage #(
        .TIME_BITS (TIME_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag_c[QUOT_BITS]),
        .quot_in  (quot_c[QUOT_BITS]),
        .rem_in   (rem_c[QUOT_BITS]),
        .div_in   (div_c[QUOT_BITS]),
        .sustain  (sustain_sat),
        .pipe_en  (pipe_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/adsr_envelope_level_tb.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level_tb
// Self-checking bench for the ADSR envelope level block. Envelope queries
// (elapsed time, note length) go in on the input stream. An independent
// integer model predicts level and segment for each accepted query. Every
// result is checked in order against that prediction, under several register
// settings and with random stalls on both streams.
// ----------------------------------------------------------------------------
module adsr_envelope_level_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    localparam int TB_TIME_BITS   = 24;
    localparam int PHASES         = 8;
    localparam int QUERIES_PER_PHASE = 160;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int REPORT_LIMIT   = 10;

    // One predicted envelope point, kept with its query for reporting
    typedef struct {
        logic [TB_TIME_BITS-1:0] elapsed;
        logic [TB_TIME_BITS-1:0] note_len;
        logic [LEVEL_BITS-1:0]   level;
        seg_t                    seg;
    } envelope_point_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, envelope predictor, in-order checker
    // ------------------------------------------------------------------------
    class envelope_scoreboard;
        logic [TB_TIME_BITS-1:0] attack_len;
        logic [TB_TIME_BITS-1:0] decay_len;
        logic [TB_TIME_BITS-1:0] release_len;
        logic [LEVEL_BITS-1:0]   sustain_raw;
        envelope_point_t         expected_q[$];
        int                      mismatches;
        int                      results_seen;
        int                      seg_hits[5];

        function new();
            attack_len   = ATTACK_RESET;
            decay_len    = DECAY_RESET;
            sustain_raw  = SUSTAIN_RESET;
            release_len  = RELEASE_RESET;
            mismatches   = 0;
            results_seen = 0;
            foreach (seg_hits[i]) seg_hits[i] = 0;
        endfunction

        // Mirror a register write; sustain keeps only its low 16 bits
        function void write_reg(reg_idx_t idx, logic [TB_TIME_BITS-1:0] value);
            case (idx)
                REG_ATTACK:  attack_len  = value;
                REG_DECAY:   decay_len   = value;
                REG_SUSTAIN: sustain_raw = value[LEVEL_BITS-1:0];
                REG_RELEASE: release_len = value;
                default: ;
            endcase
        endfunction

        // Segments are tested in order; zero-length segments never match
        function envelope_point_t compute_level(logic [TB_TIME_BITS-1:0] t_in,
                                                logic [TB_TIME_BITS-1:0] len_in);
            logic [63:0] t, len, a, d, r, s, fs, lvl;
            envelope_point_t p;
            t   = t_in;
            len = len_in;
            a   = attack_len;
            d   = decay_len;
            r   = release_len;
            fs  = 64'(FULL_SCALE);
            s   = (64'(sustain_raw) > fs) ? fs : 64'(sustain_raw);
            if (t < a) begin
                lvl   = (fs * t) / a;
                p.seg = SEG_ATTACK;
            end
            else if (t < a + d) begin
                lvl   = fs - ((fs - s) * (t - a)) / d;
                p.seg = SEG_DECAY;
            end
            else if (t + r < len) begin
                lvl   = s;
                p.seg = SEG_SUSTAIN;
            end
            else if (t < len) begin
                lvl   = (s * (len - t)) / r;
                p.seg = SEG_RELEASE;
            end
            else begin
                lvl   = 0;
                p.seg = SEG_DONE;
            end
            p.elapsed  = t_in;
            p.note_len = len_in;
            p.level    = lvl[LEVEL_BITS-1:0];
            return p;
        endfunction

        function void note_input(logic [TB_TIME_BITS-1:0] t, logic [TB_TIME_BITS-1:0] len);
            expected_q.push_back(compute_level(t, len));
        endfunction

        function void check_result(logic [LEVEL_BITS-1:0] level, logic [2:0] seg);
            envelope_point_t p;
            results_seen++;
            if (expected_q.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: unexpected result level=%0d segment=%0d", level, seg);
                mismatches++;
                return;
            end
            p = expected_q.pop_front();
            if (p.seg <= SEG_DONE)
                seg_hits[p.seg]++;
            if (level !== p.level || seg !== p.seg) begin
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: t=%0d len=%0d: level exp %0d got %0d, segment exp %0d got %0d",
                             p.elapsed, p.note_len, p.level, level, p.seg, seg);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [1:0]              cfg_addr;
    logic [TB_TIME_BITS-1:0] cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [2*TB_TIME_BITS-1:0] s_tdata;   // [23:0] elapsed, [47:24] note length
    logic                    m_tvalid;
    logic                    m_tready;
    logic [LEVEL_BITS-1:0]   m_tdata;     // [15:0] level
    logic [2:0]              m_tuser;     // [2:0] segment

    envelope_scoreboard board = new();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_request  = 1'b0;
    int idle_cycles   = 0;
    int queries_sent  = 0;

    adsr_envelope_level #(
        .TIME_BITS (TB_TIME_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one query; valid stays high into the next query unless we idle
    task automatic send_query(input logic [TB_TIME_BITS-1:0] t,
                              input logic [TB_TIME_BITS-1:0] len);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, t};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(t, len);
        queries_sent++;
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers back to back; block must be idle
    task automatic load_envelope_regs(input logic [TB_TIME_BITS-1:0] a,
                                      input logic [TB_TIME_BITS-1:0] d,
                                      input logic [TB_TIME_BITS-1:0] s,
                                      input logic [TB_TIME_BITS-1:0] r);
        logic [TB_TIME_BITS-1:0] vals[4];
        vals = '{a, d, s, r};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= reg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            board.write_reg(reg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random query aimed mostly at segment interiors and boundaries
    task automatic pick_query(output logic [TB_TIME_BITS-1:0] t,
                              output logic [TB_TIME_BITS-1:0] len);
        logic [31:0] a, d, r, tt, ll;
        a = board.attack_len;
        d = board.decay_len;
        r = board.release_len;
        case ($urandom_range(9))
            0, 1: tt = $urandom;
            2, 3: tt = (a == 0) ? 32'd0 : $urandom_range(a - 1);
            4, 5: tt = a + ((d == 0) ? 32'd0 : $urandom_range(d - 1));
            6, 7: tt = a + d + $urandom_range(2000);
            default:
                case ($urandom_range(3))
                    0: tt = a - 1;
                    1: tt = a;
                    2: tt = a + d - 1;
                    default: tt = a + d;
                endcase
        endcase
        t  = tt[TB_TIME_BITS-1:0];
        tt = {8'd0, t};
        case ($urandom_range(7))
            0, 1: ll = $urandom;
            2, 3: ll = tt + r + 1 + $urandom_range(3000);
            4, 5: ll = tt + 1 + ((r == 0) ? 32'd0 : $urandom_range(r - 1));
            6:    ll = tt - $urandom_range(50);
            default:
                case ($urandom_range(3))
                    0: ll = tt + r;
                    1: ll = tt + r + 1;
                    2: ll = tt;
                    default: ll = tt + 1;
                endcase
        endcase
        len = ll[TB_TIME_BITS-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Result side: check, then choose next ready (random, or a long hold)
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: too long with no transaction on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, board.expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [TB_TIME_BITS-1:0] t, len;
        logic [TB_TIME_BITS-1:0] a, d, s, r;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_ATTACK;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // receiver-heavy idling, then sender-heavy, then none
            if (phase < 3)
            begin
                src_idle_pct  = 35;
                sink_idle_pct = 47;
            end
            else if (phase < 6)
            begin
                src_idle_pct  = 47;
                sink_idle_pct = 35;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            // register setting for this phase; phase 0 runs on reset values
            case (phase)
                1: load_envelope_regs(24'd0, 24'd0, 24'd0, 24'd0);
                2: load_envelope_regs(24'hFFFFFF, 24'hFFFFFF, 24'd32768, 24'hFFFFFF);
                3: load_envelope_regs(24'd1, 24'd1, 24'h00FFFF, 24'd1);
                4: load_envelope_regs(24'd1000, 24'd0, 24'hAB4000, 24'd5000);
                6: load_envelope_regs(24'd16, 24'hFFFFFF, 24'd1, 24'd0);
                5, 7:
                begin
                    a = $urandom_range(3000);
                    d = $urandom_range(6000);
                    s = $urandom_range(32768);
                    r = $urandom_range(6000);
                    load_envelope_regs(a, d, s, r);
                end
                default: ;
            endcase

            // directed corners on reset values: field extremes and boundaries
            if (phase == 0)
            begin
                send_query(24'd0, 24'd0);
                send_query(24'hFFFFFF, 24'hFFFFFF);
                send_query(24'd0, 24'hFFFFFF);
                send_query(24'hFFFFFF, 24'd0);
                send_query(24'd440, 24'd100000);
                send_query(24'd441, 24'd100000);
                send_query(24'd4850, 24'd100000);
                send_query(24'd4851, 24'd100000);
                send_query(24'd5000, 24'd20000);
                send_query(24'd15589, 24'd20000);
                send_query(24'd15590, 24'd20000);
                send_query(24'd16000, 24'd20000);
                send_query(24'd19999, 24'd20000);
                send_query(24'd20000, 24'd20000);
            end
            // release longer than the note itself
            if (phase == 4)
            begin
                send_query(24'd1500, 24'd3000);
                send_query(24'd1000, 24'd1001);
            end

            for (int k = 0; k < QUERIES_PER_PHASE; k++)
            begin
                // long output stall with input still offered
                if (phase >= 6 && k == 50)
                    hold_request = 1'b1;
                // sender waits for the pipeline to empty mid phase
                if (phase == 5 && k == 80)
                    drain_results();
                pick_query(t, len);
                send_query(t, len);
            end
            drain_results();
        end

        repeat (30) @(posedge clk);
        $display("Ran %0d envelope queries over %0d register settings, %0d results checked",
                 queries_sent, PHASES, board.results_seen);
        $display("Segments hit: attack %0d decay %0d sustain %0d release %0d finished %0d",
                 board.seg_hits[0], board.seg_hits[1], board.seg_hits[2],
                 board.seg_hits[3], board.seg_hits[4]);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d results missing",
                     board.mismatches, board.expected_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
